>>> rtl/core/tfbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbsd_pkg
// Shared widths, register indexes and the divider result type for the
// time/frequency block-sum decimator.
// ----------------------------------------------------------------------------
package tfbsd_pkg;

  // channel counters and channel-count register
  localparam int CNT_W    = 13;
  // time/channel factor registers
  localparam int FAC_W    = 7;
  // in-group positions and divider remainder (factor at most 64)
  localparam int POS_W    = 6;
  localparam int SUM_W    = 28;
  localparam int OUT_CH_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = $clog2(CNT_W);

  localparam logic [FAC_W-1:0] FAC_MAX = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_FACTOR    = 2'd0,
    CFG_CHAN_FACTOR    = 2'd1,
    CFG_INPUT_CHANNELS = 2'd2
  } cfg_idx_t;

  // divider status and result
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] quot;
    logic [POS_W-1:0] rem;
  } div_res_t;

endpackage

>>> rtl/core/tfbsd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbsd_div
// Restoring divider, one quotient bit per cycle: a channel count by a factor.
// ----------------------------------------------------------------------------
module tfbsd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tfbsd_pkg::CNT_W-1:0]   dividend,
  input  logic [tfbsd_pkg::FAC_W-1:0]   divisor,
  output tfbsd_pkg::div_res_t           res
);
  import tfbsd_pkg::*;

  logic [CNT_W-1:0]  dvd_r, dvd_nxt;
  logic [POS_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [FAC_W-1:0]  trial;
  logic [FAC_W-1:0]  diff;
  logic              ge;

  always_comb begin
    // remainder stays below the divisor, so it fits POS_W bits
    trial = {rem_r, dvd_r[CNT_W-1]};
    ge    = (trial >= divisor);
    diff  = trial - divisor;

    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[CNT_W-2:0], ge};
      rem_nxt  = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = dvd_r;
  assign res.rem  = rem_r;

endmodule

>>> rtl/core/time_frequency_block_sum_decimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_frequency_block_sum_decimator_top
// Sums blocks of time_factor spectra by chan_factor channels of filterbank
// samples, keeping per-output-channel partial sums in a line store.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_sample                  | sink
//  out     | out_valid, out_ready, out_block_sum,           | source
//          | out_channel, out_last_in_spectrum              |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | sink
//
//  One item per cycle sustained while in_ready is high. Items that finish a
//  channel group take two stages: a line-store read, then add and write
//  back; back-to-back updates of the same entry are forwarded around the
//  registered read. After reset and after every register write, in_ready
//  stays low while a 13-step serial divider works out the output channel
//  count and the position of the channel counter. The store needs no
//  clearing. Apart from that hold-off, in_ready drops only when a finished
//  sum waits in stage two behind an output register that is still full.
//
module time_frequency_block_sum_decimator_top #(
  parameter int MAX_CHANNELS = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tfbsd_pkg::SUM_W-1:0] out_block_sum,
  output logic [tfbsd_pkg::OUT_CH_W-1:0]    out_channel,
  output logic                              out_last_in_spectrum,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tfbsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfbsd_pkg::CNT_W-1:0]       cfg_data
);
  import tfbsd_pkg::*;

  // line store address width
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // channel-group sum: up to 64 samples, kept modulo the output width
  localparam int GW = (SAMPLE_BITS + POS_W > SUM_W) ? SUM_W : SAMPLE_BITS + POS_W;
  // channel register can hold at most 8191
  localparam int IC_CAP = (MAX_CHANNELS > (1 << CNT_W) - 1) ?
                          (1 << CNT_W) - 1 : MAX_CHANNELS;
  localparam logic [CNT_W-1:0] IC_MAX = CNT_W'(IC_CAP);

  // stage-two control
  typedef struct packed {
    logic [CNT_W-1:0] o;      // output channel
    logic             first;  // first spectrum of the time group
    logic             emit;   // last spectrum: sum goes out
    logic             last;   // last output channel of the spectrum
  } s1_ctl_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [FAC_W-1:0] tf_r, tf_nxt;
  logic [FAC_W-1:0] cf_r, cf_nxt;
  logic [CNT_W-1:0] ic_r, ic_nxt;
  logic             div_start_r, div_start_nxt;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_comb begin
    tf_nxt = tf_r;
    cf_nxt = cf_r;
    ic_nxt = ic_r;
    if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIME_FACTOR:    tf_nxt = cfg_data[FAC_W-1:0];
        CFG_CHAN_FACTOR:    cf_nxt = cfg_data[FAC_W-1:0];
        CFG_INPUT_CHANNELS: ic_nxt = cfg_data;
        default: ;          // index past the register list: ignored
      endcase
    end
    // any write re-runs the divider with the updated registers
    div_start_nxt = cfg_fire;
  end

  // clamped register values
  logic [FAC_W-1:0] tf_c, cf_c;
  logic [CNT_W-1:0] ic_c, ic_m1;
  logic [POS_W-1:0] tf_m1, cf_m1;

  always_comb begin
    tf_c  = (tf_r == '0) ? FAC_W'(1) : ((tf_r > FAC_MAX) ? FAC_MAX : tf_r);
    cf_c  = (cf_r == '0) ? FAC_W'(1) : ((cf_r > FAC_MAX) ? FAC_MAX : cf_r);
    ic_c  = (ic_r == '0) ? CNT_W'(1) : ((ic_r > IC_MAX) ? IC_MAX : ic_r);
    tf_m1 = POS_W'(tf_c - FAC_W'(1));
    cf_m1 = POS_W'(cf_c - FAC_W'(1));
    ic_m1 = ic_c - CNT_W'(1);
  end

  // --------------------------------------------------------------------------
  // dividers: channels / chan_factor, and channel counter / chan_factor
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] cc_r, cc_nxt;   // input channel within the spectrum
  div_res_t         oc_res, pos_res;
  logic             busy;

  tfbsd_div u_div_oc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (ic_c),
    .divisor  (cf_c),
    .res      (oc_res)
  );

  tfbsd_div u_div_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (cc_r),
    .divisor  (cf_c),
    .res      (pos_res)
  );

  // hold items off until the derived counts are loaded
  assign busy = div_start_r | oc_res.busy | oc_res.done | pos_res.busy | pos_res.done;

  // --------------------------------------------------------------------------
  // stage one: counters and channel-group sum
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]      cig_r, cig_nxt;   // channel within group
  logic [POS_W-1:0]      sig_r, sig_nxt;   // spectrum within time group
  logic signed [GW-1:0]  gs_r, gs_nxt;     // channel-group sum
  logic [CNT_W-1:0]      q_r, q_nxt;       // cc / chan_factor
  logic [POS_W-1:0]      r_r, r_nxt;       // cc % chan_factor
  logic [CNT_W-1:0]      lim_r, lim_nxt;   // out_channels * chan_factor
  logic [CNT_W-1:0]      oc_m1_r, oc_m1_nxt;

  s1_ctl_t               s1_r, s1_nxt;
  logic signed [GW-1:0]  s1_gs_r, s1_gs_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_go;

  logic                  fwd_r, fwd_nxt;
  logic [SUM_W-1:0]      fwd_data_r;
  logic [SUM_W-1:0]      rd_data_r;
  logic [SUM_W-1:0]      base;
  logic [SUM_W-1:0]      ps;

  logic                  in_fire;
  logic                  in_range;
  logic                  complete;
  logic                  wrap;
  logic signed [GW-1:0]  s_ext;

  logic                  out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]      out_sum_r;
  logic [OUT_CH_W-1:0]   out_ch_r;
  logic                  out_last_r;

  // stage two moves unless its sum must go out and the output is full
  assign s1_go    = s1_valid_r & (~s1_r.emit | ~out_valid_r | out_ready);
  assign in_ready = ~busy & (~s1_valid_r | s1_go);
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    s_ext    = GW'(in_sample);
    in_range = (cc_r < lim_r);
    complete = in_range & (cig_r >= cf_m1);
    wrap     = (cc_r >= ic_m1);

    cc_nxt    = cc_r;
    cig_nxt   = cig_r;
    sig_nxt   = sig_r;
    gs_nxt    = gs_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    lim_nxt   = lim_r;
    oc_m1_nxt = oc_m1_r;

    s1_nxt       = s1_r;
    s1_gs_nxt    = s1_gs_r;
    s1_valid_nxt = s1_valid_r & ~s1_go;
    fwd_nxt      = fwd_r;

    if (oc_res.done) begin
      lim_nxt   = ic_c - CNT_W'(oc_res.rem);
      oc_m1_nxt = oc_res.quot - CNT_W'(1);
    end
    if (pos_res.done) begin
      q_nxt = pos_res.quot;
      r_nxt = pos_res.rem;
    end

    if (in_fire) begin
      if (in_range) begin
        gs_nxt = (cig_r == '0) ? s_ext : gs_r + s_ext;
        if (complete) begin
          cig_nxt      = '0;
          s1_valid_nxt = 1'b1;
          s1_nxt.o     = q_r;
          s1_nxt.first = (sig_r == '0);
          s1_nxt.emit  = (sig_r >= tf_m1);
          s1_nxt.last  = (q_r == oc_m1_r);
          s1_gs_nxt    = gs_nxt;
          // entry being written back this cycle: the read sees stale data
          fwd_nxt      = s1_go & (s1_r.o == q_r);
        end else begin
          cig_nxt = cig_r + 1'b1;
        end
      end

      if (wrap) begin
        cc_nxt  = '0;
        cig_nxt = '0;
        q_nxt   = '0;
        r_nxt   = '0;
        sig_nxt = (sig_r >= tf_m1) ? '0 : sig_r + 1'b1;
      end else begin
        cc_nxt = cc_r + 1'b1;
        if (r_r == cf_m1) begin
          q_nxt = q_r + 1'b1;
          r_nxt = '0;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // line store: read on completion, write back from stage two
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sums_mem [MAX_CHANNELS];
  logic             rd_en;

  assign rd_en = in_fire & complete;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= sums_mem[AW'(q_r)];
    end
    if (s1_go) begin
      sums_mem[AW'(s1_r.o)] <= ps;
    end
  end

  // --------------------------------------------------------------------------
  // stage two: accumulate and hand to the output register
  // --------------------------------------------------------------------------
  always_comb begin
    base = fwd_r ? fwd_data_r : rd_data_r;
    ps   = (s1_r.first ? '0 : base) + SUM_W'(s1_gs_r);
    out_valid_nxt = (out_valid_r & ~out_ready) | (s1_go & s1_r.emit);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= ps;
    end
    if (s1_go & s1_r.emit) begin
      out_sum_r  <= ps;
      out_ch_r   <= s1_r.o[OUT_CH_W-1:0];
      out_last_r <= s1_r.last;
    end
    s1_r    <= s1_nxt;
    s1_gs_r <= s1_gs_nxt;
    gs_r    <= gs_nxt;
    if (!rst_n) begin
      tf_r        <= FAC_W'(1);
      cf_r        <= FAC_W'(1);
      ic_r        <= CNT_W'(4096);
      div_start_r <= 1'b1;
      cc_r        <= '0;
      cig_r       <= '0;
      sig_r       <= '0;
      q_r         <= '0;
      r_r         <= '0;
      lim_r       <= '0;
      oc_m1_r     <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tf_r        <= tf_nxt;
      cf_r        <= cf_nxt;
      ic_r        <= ic_nxt;
      div_start_r <= div_start_nxt;
      cc_r        <= cc_nxt;
      cig_r       <= cig_nxt;
      sig_r       <= sig_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      lim_r       <= lim_nxt;
      oc_m1_r     <= oc_m1_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_block_sum        = out_sum_r;
  assign out_channel          = out_ch_r;
  assign out_last_in_spectrum = out_last_r;

`ifndef SYNTHESIS
  // a stalled stage two keeps its entry until it writes back
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_r.o))
    else $error("stage two lost its entry while stalled");

  // channel remainder stays below the factor whenever items are taken
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ({1'b0, r_r} < cf_c))
    else $error("channel remainder out of range");

  // a new result only comes from a finished sum in stage two
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(s1_go && s1_r.emit))
    else $error("result appeared without a finished sum");
`endif

endmodule

>>> tb/sv/time_frequency_block_sum_decimator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_frequency_block_sum_decimator_top_test
// Self-checking bench for the block-sum decimator. Samples are pushed through
// the valid/ready input while an in-bench predictor tracks the counters, the
// line store and the registers, and queues the block sums each item should
// produce. Every result leaving the block is compared field by field with the
// oldest queued sum.
// ----------------------------------------------------------------------------
module time_frequency_block_sum_decimator_top_test;
  import tfbsd_pkg::*;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_CH          = 4096;
  // two pipeline stages plus the output register, with margin
  localparam int DRAIN_CYCLES    = 8;
  // longest legal stretch without any handshake is the hold-off below
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [SUM_W-1:0]    block_sum;
    logic [OUT_CH_W-1:0] out_channel;
    logic                last_in_spectrum;
  } block_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; everything the bench drives starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sample_t               in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_block_sum;
  logic [OUT_CH_W-1:0]   out_channel;
  logic                  out_last_in_spectrum;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CNT_W-1:0]      cfg_data  = '0;

  time_frequency_block_sum_decimator_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_block_sum        (out_block_sum),
    .out_channel          (out_channel),
    .out_last_in_spectrum (out_last_in_spectrum),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, counters and line store
  // ---------------------------------------------------------------------------
  logic [FAC_W-1:0] time_factor_q = 7'd1;
  logic [FAC_W-1:0] chan_factor_q = 7'd1;
  logic [CNT_W-1:0] in_chans_q    = 13'd4096;
  logic [SUM_W-1:0] line_sums [MAX_CH];
  int               group_acc = 0;   // running sum over the channel group
  int unsigned      chan_pos  = 0;   // input channel within the spectrum
  int unsigned      grp_pos   = 0;   // position inside the channel group
  int unsigned      spec_pos  = 0;   // spectrum inside the time group

  block_result_t block_sums_due[$];

  // pacing knobs, percent of cycles spent idle
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_off_left = 0;

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int stall_cycles   = 0;

  // 0 acts as 1, anything above 64 as 64
  function automatic int unsigned clamp_factor(input logic [FAC_W-1:0] f);
    if (f == 0) return 1;
    if (f > FAC_MAX) return FAC_MAX;
    return f;
  endfunction

  // Advance the predictor by one accepted sample and queue a block sum when
  // the sample closes a block in the last spectrum of its time group.
  task automatic predict_block_sum(input sample_t s);
    int unsigned   tf, cf, ic, oc, o;
    logic [SUM_W-1:0] acc;
    block_result_t r;
    tf = clamp_factor(time_factor_q);
    cf = clamp_factor(chan_factor_q);
    ic = (in_chans_q == 0) ? 1 : (in_chans_q > MAX_CH) ? MAX_CH : in_chans_q;
    oc = ic / cf;
    // channels past the last full group are dropped
    if (chan_pos < oc * cf) begin
      if (grp_pos == 0) group_acc = s;
      else group_acc = group_acc + s;
      if (grp_pos >= cf - 1) begin
        o = chan_pos / cf;
        if (o < MAX_CH) begin
          // first spectrum of the time group overwrites the entry
          if (spec_pos == 0) acc = SUM_W'(group_acc);
          else acc = line_sums[o] + SUM_W'(group_acc);
          line_sums[o] = acc;
        end else begin
          acc = SUM_W'(group_acc);
        end
        if (spec_pos >= tf - 1) begin
          r.block_sum        = acc;
          r.out_channel      = o[OUT_CH_W-1:0];
          r.last_in_spectrum = (o == oc - 1);
          block_sums_due.push_back(r);
        end
        grp_pos = 0;
      end else begin
        grp_pos = (grp_pos + 1) & 32'h3F;
      end
    end
    // counters wrap with >= so a register change mid-spectrum wraps next time
    if (chan_pos >= ic - 1) begin
      chan_pos = 0;
      grp_pos  = 0;
      spec_pos = (spec_pos >= tf - 1) ? 0 : ((spec_pos + 1) & 32'h3F);
    end else begin
      chan_pos = (chan_pos + 1) & 32'hFFFF;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pacing with an optional long hold-off, then checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
    $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    block_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (block_sums_due.size() == 0) begin
        report_mismatch("unexpected result, block_sum", '0, out_block_sum);
      end else begin
        want = block_sums_due.pop_front();
        if (out_block_sum !== want.block_sum)
          report_mismatch("block_sum", want.block_sum, out_block_sum);
        if (out_channel !== want.out_channel)
          report_mismatch("out_channel", SUM_W'(want.out_channel), SUM_W'(out_channel));
        if (out_last_in_spectrum !== want.last_in_spectrum)
          report_mismatch("last_in_spectrum", SUM_W'(want.last_in_spectrum),
                          SUM_W'(out_last_in_spectrum));
      end
    end
  end

  // Watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("time_frequency_block_sum_decimator_top_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one item; valid is left high after acceptance so back-to-back
  // items never lower and raise it in the same step.
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_block_sum(s);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // At least min_items random samples, then up to the end of the time group
  // so the next register write finds every counter at zero.
  task automatic send_random_groups(input int min_items);
    repeat (min_items) send_sample(random_sample());
    while (chan_pos != 0 || spec_pos != 0) send_sample(random_sample());
  endtask

  // Drop valid, wait for all queued sums, then let the pipeline settle
  // (items closing no block leave nothing in the queue to wait on).
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (block_sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_TIME_FACTOR:    time_factor_q = val[FAC_W-1:0];
      CFG_CHAN_FACTOR:    chan_factor_q = val[FAC_W-1:0];
      CFG_INPUT_CHANNELS: in_chans_q    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CNT_W-1:0] tf, input logic [CNT_W-1:0] cf,
                              input logic [CNT_W-1:0] ic);
    write_reg(CFG_TIME_FACTOR, tf);
    write_reg(CFG_CHAN_FACTOR, cf);
    write_reg(CFG_INPUT_CHANNELS, ic);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset registers: 4096 channels, no decimation. Corner samples come back
  // as one-sample sums; the spectrum stays open and the time factor is 1, so
  // the next register write only wraps the channel counter.
  task automatic test_full_width_spectrum();
    sample_t corner_samples[7];
    corner_samples = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                       16'sh0001, 16'sh5555, 16'shAAAA};
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
  endtask

  // Out-of-range register values and the unused register index.
  task automatic test_register_clamps();
    set_geometry(13'd0, 13'd0, 13'd0);              // all act as 1
    send_random_groups(4);
    write_reg(CFG_UNUSED, 13'h1FFF);                 // no register behind it
    send_random_groups(3);
    set_geometry(13'h1FC0, 13'd2, 13'd3);           // tf 64, last channel dropped
    send_random_groups(1);
    set_geometry(13'h1F81, 13'd127, 13'd8191);      // tf 1, cf 64, 4096 channels
    repeat (64) send_sample(random_sample());       // one output channel
  endtask

  // Channel factor wider than the spectrum: every sample dropped.
  task automatic test_too_few_channels();
    set_geometry(13'd1, 13'd2, 13'd1);
    send_random_groups(20);
  endtask

  // Widest channel groups over two spectra, full of the most negative, then
  // the most positive sample: the group sum reaches its floor and the block
  // sum grows past it.
  task automatic test_block_sum_extremes();
    set_geometry(13'd2, 13'd64, 13'd64);
    repeat (2 * 64) send_sample(16'sh8000);
    repeat (2 * 64) send_sample(16'sh7FFF);
  endtask

  // Registers change halfway through a spectrum. Time factor stays 1, so the
  // line store is only ever overwritten and its read data is never used.
  task automatic test_mid_stream_change();
    set_geometry(13'd1, 13'd4, 13'd10);
    repeat (7) send_sample(random_sample());        // group position now 3
    write_reg(CFG_CHAN_FACTOR, 13'd2);              // position past new limit
    send_sample(random_sample());
    write_reg(CFG_INPUT_CHANNELS, 13'd4);           // channel count past limit
    send_random_groups(5);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_stall();
    int saved_pct;
    saved_pct = in_idle_pct;
    set_geometry(13'd1, 13'd1, 13'd16);
    in_idle_pct = 0;
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    send_random_groups(64);
    in_idle_pct = saved_pct;
  endtask

  // Random geometries, raw values now and then out of range. The product of
  // time factor and channel count is kept small so groups close quickly.
  task automatic run_random_segment();
    logic [CNT_W-1:0] tf_raw, cf_raw, ic_raw;
    int unsigned      ic_cap, ic_eff;
    tf_raw = ($urandom_range(5) == 0) ? CNT_W'($urandom_range(8191))
                                      : CNT_W'($urandom_range(1, 8));
    ic_cap = 256 / clamp_factor(tf_raw[FAC_W-1:0]);
    if (ic_cap > 64) ic_cap = 64;
    ic_raw = ($urandom_range(7) == 0) ? '0 : CNT_W'($urandom_range(1, ic_cap));
    ic_eff = (ic_raw == 0) ? 1 : ic_raw;
    cf_raw = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(8191))
                                      : CNT_W'($urandom_range(1, ic_eff + 1));
    set_geometry(tf_raw, cf_raw, ic_raw);
    send_random_groups($urandom_range(20, 80));
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct,
                                     input int item_count);
    int first_item;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    first_item   = items_sent;
    while (items_sent - first_item < item_count) run_random_segment();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    in_idle_pct  = 24;
    out_idle_pct = 51;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_full_width_spectrum();
    test_register_clamps();
    test_too_few_channels();
    test_block_sum_extremes();
    test_mid_stream_change();
    test_output_stall();
    test_random_traffic(24, 51, 80);
    test_random_traffic(51, 24, 80);
    test_random_traffic(0, 0, 80);

    wait_drained();
    $display("Sent %0d samples, checked %0d block sums, made %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Covered clamped registers, dropped channels, mid-spectrum changes, stalls.");
    if (mismatch_count == 0) begin
      $display("time_frequency_block_sum_decimator_top_test OK");
    end else begin
      $display("time_frequency_block_sum_decimator_top_test NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tfbsd_pkg.sv
rtl/core/tfbsd_div.sv
rtl/core/time_frequency_block_sum_decimator_top.sv
tb/sv/time_frequency_block_sum_decimator_top_test.sv
